// ===== src/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared constants, key and event codes and types of the keypad code lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

    // Field widths
    localparam int ENTRY_W = 14;
    localparam int COUNT_W = 3;
    localparam int KEY_W   = 5;
    localparam int EV_W    = 3;
    localparam int TICK_W  = 16;
    localparam int FAIL_W  = 4;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Longest entry in digits
    localparam int MAX_DIGITS = 4;

    // Reset values of the registers
    localparam logic [ENTRY_W-1:0] DEFAULT_CODE_RST  = ENTRY_W'(1234);
    localparam logic [TICK_W-1:0]  TIMEOUT_TICKS_RST = TICK_W'(3000);
    localparam logic [FAIL_W-1:0]  FAILURE_LIMIT_RST = FAIL_W'(3);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_LIMIT = 2'd2;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_DIGIT_FIRST = 5'd1;
    localparam logic [KEY_W-1:0] KEY_DIGIT_LAST  = 5'd10;
    localparam logic [KEY_W-1:0] KEY_ZERO        = 5'd10;
    localparam logic [KEY_W-1:0] KEY_CONFIRM     = 5'd13;
    localparam logic [KEY_W-1:0] KEY_DELETE      = 5'd14;
    localparam logic [KEY_W-1:0] KEY_CHANGE      = 5'd15;
    localparam logic [KEY_W-1:0] KEY_SAVE        = 5'd16;

    // Request kinds
    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Event codes
    localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EV_W-1:0] EV_ACCEPT  = 3'd1;
    localparam logic [EV_W-1:0] EV_REJECT  = 3'd2;
    localparam logic [EV_W-1:0] EV_SAVED   = 3'd3;
    localparam logic [EV_W-1:0] EV_TIMEOUT = 3'd4;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // Reciprocal of ten: (x * 52429) >> 19 == x / 10 for every 14-bit x
    localparam int               DIV10_W     = 16;
    localparam logic [DIV10_W-1:0] DIV10_MUL = 16'd52429;
    localparam int               DIV10_SHIFT = 19;

    // Control from the sequencer to the entry buffer
    typedef struct packed {
        logic             key_act;   // a live key request is being processed
        logic             clear;     // confirm or save empties the entry
        logic [KEY_W-1:0] key_code;
    } entry_ctl_t;

endpackage

// ===== src/kcl_entry.sv =====
// ----------------------------------------------------------------------------
// kcl_entry
// Digit entry buffer update: append a decimal digit, delete the last one,
// or clear the entry.
// ----------------------------------------------------------------------------
module kcl_entry (
    input  kcl_pkg::entry_ctl_t           ctl,
    input  logic [kcl_pkg::ENTRY_W-1:0]   entry_cur,
    input  logic [kcl_pkg::COUNT_W-1:0]   count_cur,
    output logic [kcl_pkg::ENTRY_W-1:0]   entry_new,
    output logic [kcl_pkg::COUNT_W-1:0]   count_new
);
    import kcl_pkg::*;

    logic [ENTRY_W+3:0]          times_ten;
    logic [ENTRY_W+DIV10_W-1:0]  recip_prod;
    logic [ENTRY_W-1:0]          div_ten;
    logic [3:0]                  digit;
    logic                        is_digit;
    logic                        room;

    // x*10 = x*8 + x*2
    assign times_ten  = {1'b0, entry_cur, 3'b000} + {3'b000, entry_cur, 1'b0};
    assign recip_prod = entry_cur * DIV10_MUL;
    assign div_ten    = ENTRY_W'(recip_prod >> DIV10_SHIFT);
    assign digit      = (ctl.key_code == KEY_ZERO) ? 4'd0 : ctl.key_code[3:0];
    assign room       = (count_cur < COUNT_W'(MAX_DIGITS));

    always_comb
    begin
        is_digit = ctl.key_code inside {[KEY_DIGIT_FIRST:KEY_DIGIT_LAST]};
        entry_new = entry_cur;
        count_new = count_cur;
        if (ctl.clear)
        begin
            entry_new = '0;
            count_new = '0;
        end
        else if (ctl.key_act && is_digit && room)
        begin
            // wrap to the entry width
            entry_new = ENTRY_W'(times_ten + {{(ENTRY_W){1'b0}}, digit});
            count_new = count_cur + COUNT_W'(1);
        end
        else if (ctl.key_act && ctl.key_code == KEY_DELETE && count_cur != '0)
        begin
            entry_new = div_ten;
            count_new = count_cur - COUNT_W'(1);
        end
    end

endmodule

// ===== src/keypad_code_lock.sv =====
// ----------------------------------------------------------------------------
// keypad_code_lock
// Four-digit keypad code lock with failure alarm and unlock timeout.
//
// Each request is either a keypad event (func 0, key 1..16) or a one
// millisecond tick (func 1) and gives exactly one result showing the lock
// state after it. Requests are taken one per clock while results are taken;
// a result passes from the input register to the result register and
// shows on the port from there. While a finished result waits on
// out_stall, the request stage takes one more request and holds it, and
// then the input stalls. Digit keys 1..10 build an entry of
// up to four digits (10
// is zero), key 14 deletes, key 13 checks the entry against the stored
// code, key 15 enters change mode once unlocked and key 16 saves the new
// code. Saving or running out the timeout halts the lock: from then on
// every request returns the frozen state with no event until reset.
// Writing default_code loads the stored code at once; timeout_ticks and
// failure_limit take effect with the next request. Write the registers
// only while no request is in flight. There is no clearing pass after
// reset.
// ----------------------------------------------------------------------------
module keypad_code_lock (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kcl_pkg::CFG_W-1:0]       cfg_data,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic [kcl_pkg::KEY_W-1:0]       key_code,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [kcl_pkg::ENTRY_W-1:0]     entry_value,
    output logic [kcl_pkg::COUNT_W-1:0]     digit_count,
    output logic                            unlocked,
    output logic                            change_mode,
    output logic [kcl_pkg::EV_W-1:0]        event_res,
    output logic                            alarm,
    output logic                            halted
);
    import kcl_pkg::*;

    // configuration
    logic [TICK_W-1:0]  timeout_ticks_reg;
    logic [FAIL_W-1:0]  failure_limit_reg;

    // request stage
    logic               s1_valid_reg;
    logic               s1_func_reg;
    logic [KEY_W-1:0]   s1_key_reg;

    // lock state
    logic [ENTRY_W-1:0] entry_reg,     entry_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic [ENTRY_W-1:0] stored_reg,    stored_next;
    logic [FAIL_W-1:0]  failure_reg,   failure_next;
    logic               unlocked_reg,  unlocked_next;
    logic               change_reg,    change_next;
    logic               timer_reg,     timer_next;
    logic [TICK_W-1:0]  tick_reg,      tick_next;
    logic               halted_reg,    halted_next;
    logic [EV_W-1:0]    ev_next;

    // result register
    logic               out_valid_reg;
    logic [ENTRY_W-1:0] res_entry_reg;
    logic [COUNT_W-1:0] res_count_reg;
    logic               res_unlocked_reg;
    logic               res_change_reg;
    logic [EV_W-1:0]    res_ev_reg;
    logic               res_alarm_reg;
    logic               res_halted_reg;

    logic               advance;
    logic               fire;
    logic               in_take;
    logic               key_act;
    logic               tick_act;
    logic [TICK_W-1:0]  tick_inc;
    entry_ctl_t         entry_ctl;

    // Result register frees up when empty or when its result is taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign key_act  = fire && !halted_reg && (s1_func_reg == FUNC_KEY);
    assign tick_act = fire && !halted_reg && (s1_func_reg == FUNC_TICK) && timer_reg;
    assign tick_inc = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + TICK_W'(1);

    // Sequencer: confirm/change first, entry edits in kcl_entry, then save.
    always_comb
    begin
        stored_next   = stored_reg;
        failure_next  = failure_reg;
        unlocked_next = unlocked_reg;
        change_next   = change_reg;
        timer_next    = timer_reg;
        tick_next     = tick_reg;
        halted_next   = halted_reg;
        ev_next       = EV_NONE;
        entry_ctl.key_act  = key_act;
        entry_ctl.key_code = s1_key_reg;
        entry_ctl.clear    = 1'b0;

        if (key_act)
        begin
            if (!unlocked_reg && s1_key_reg == KEY_CONFIRM)
            begin
                entry_ctl.clear = 1'b1;
                if (entry_reg == stored_reg)
                begin
                    failure_next  = '0;
                    unlocked_next = 1'b1;
                    timer_next    = 1'b1;
                    tick_next     = '0;
                    ev_next       = EV_ACCEPT;
                end
                else
                begin
                    // saturate at the limit
                    if (failure_reg < failure_limit_reg)
                        failure_next = failure_reg + FAIL_W'(1);
                    ev_next = EV_REJECT;
                end
            end
            else if (unlocked_reg && s1_key_reg == KEY_CHANGE)
            begin
                change_next = 1'b1;
                timer_next  = 1'b0;
                tick_next   = '0;
            end

            if (s1_key_reg == KEY_SAVE && change_reg)
            begin
                stored_next     = entry_reg;
                change_next     = 1'b0;
                unlocked_next   = 1'b0;
                timer_next      = 1'b0;
                tick_next       = '0;
                halted_next     = 1'b1;
                entry_ctl.clear = 1'b1;
                ev_next         = EV_SAVED;
            end
        end
        else if (tick_act)
        begin
            if (tick_inc >= timeout_ticks_reg)
            begin
                timer_next  = 1'b0;
                tick_next   = '0;
                halted_next = 1'b1;
                ev_next     = EV_TIMEOUT;
            end
            else
            begin
                tick_next = tick_inc;
            end
        end
    end

    kcl_entry u_entry (
        .ctl       (entry_ctl),
        .entry_cur (entry_reg),
        .count_cur (count_reg),
        .entry_new (entry_next),
        .count_new (count_next)
    );

    // Configuration registers; a default_code write reloads the stored code.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
            failure_limit_reg <= FAILURE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                CFG_FAILURE_LIMIT: failure_limit_reg <= cfg_data[FAIL_W-1:0];
                default: ;
            endcase
        end
    end

    // Request stage: load whenever the slot is empty or moving on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!s1_valid_reg || advance)
            s1_valid_reg <= in_take;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_func_reg <= func;
            s1_key_reg  <= key_code;
        end
    end

    // Lock state: advance on every processed request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg    <= '0;
            count_reg    <= '0;
            stored_reg   <= DEFAULT_CODE_RST;
            failure_reg  <= '0;
            unlocked_reg <= 1'b0;
            change_reg   <= 1'b0;
            timer_reg    <= 1'b0;
            tick_reg     <= '0;
            halted_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_DEFAULT_CODE)
                stored_reg <= cfg_data[ENTRY_W-1:0];
            else if (fire)
                stored_reg <= stored_next;
            if (fire)
            begin
                entry_reg    <= entry_next;
                count_reg    <= count_next;
                failure_reg  <= failure_next;
                unlocked_reg <= unlocked_next;
                change_reg   <= change_next;
                timer_reg    <= timer_next;
                tick_reg     <= tick_next;
                halted_reg   <= halted_next;
            end
        end
    end

    // Result register: hold while stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_entry_reg    <= entry_next;
            res_count_reg    <= count_next;
            res_unlocked_reg <= unlocked_next;
            res_change_reg   <= change_next;
            res_ev_reg       <= ev_next;
            res_alarm_reg    <= (failure_next >= failure_limit_reg);
            res_halted_reg   <= halted_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign entry_value = res_entry_reg;
    assign digit_count = res_count_reg;
    assign unlocked    = res_unlocked_reg;
    assign change_mode = res_change_reg;
    assign event_res   = res_ev_reg;
    assign alarm       = res_alarm_reg;
    assign halted      = res_halted_reg;

    // Once halted, only reset brings the lock back.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halted state left without reset");

    // Change mode exists only inside an unlocked session.
    a_change_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
        change_reg |-> unlocked_reg)
        else $error("change mode while locked");

    // The timer runs only while unlocked and not changing the code.
    a_timer_session: assert property (@(posedge clk) disable iff (!rst_n)
        timer_reg |-> (unlocked_reg && !change_reg && !halted_reg))
        else $error("timer running outside an unlocked session");

    // The entry never holds more digits than allowed.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_DIGITS))
        else $error("digit count beyond limit");

    // A save or timeout result always reports the halt.
    a_final_event: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (res_ev_reg == EV_SAVED || res_ev_reg == EV_TIMEOUT))
        |-> res_halted_reg)
        else $error("terminal event without halt");

endmodule

// ===== bench/kcl_lock_checker.sv =====
// ----------------------------------------------------------------------------
// kcl_lock_checker
// Watches the request, result and register ports of the keypad code lock,
// predicts the lock state after every accepted request and compares each
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module kcl_lock_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kcl_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            func,
    input  logic [kcl_pkg::KEY_W-1:0]       key_code,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [kcl_pkg::ENTRY_W-1:0]     entry_value,
    input  logic [kcl_pkg::COUNT_W-1:0]     digit_count,
    input  logic                            unlocked,
    input  logic                            change_mode,
    input  logic [kcl_pkg::EV_W-1:0]        event_res,
    input  logic                            alarm,
    input  logic                            halted,
    output int                              mismatches,
    output int                              pending
);
    import kcl_pkg::*;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry;
        logic [COUNT_W-1:0] digits;
        logic               unl;
        logic               chg;
        logic [EV_W-1:0]    ev;
        logic               alarm;
        logic               halt;
    } lock_view_t;

    // Shadow of the lock state and its registers
    logic [ENTRY_W-1:0] entry_sh;
    logic [COUNT_W-1:0] digits_sh;
    logic [ENTRY_W-1:0] code_sh;
    logic [FAIL_W-1:0]  fails_sh;
    logic               unl_sh;
    logic               chg_sh;
    logic               run_sh;
    logic [TICK_W-1:0]  ticks_sh;
    logic               halt_sh;
    logic [TICK_W-1:0]  tmo_cfg;
    logic [FAIL_W-1:0]  lim_cfg;

    lock_view_t expected_views[$];
    lock_view_t want;
    lock_view_t got;

    function automatic lock_view_t predict_lock_view(input logic kind,
                                                     input logic [KEY_W-1:0] key);
        lock_view_t v;
        logic [EV_W-1:0] ev;
        ev = EV_NONE;
        if (!halt_sh) begin
            if (kind == FUNC_KEY) begin
                if (!unl_sh) begin
                    if (key == KEY_CONFIRM) begin
                        if (entry_sh == code_sh) begin
                            fails_sh = '0;
                            unl_sh   = 1'b1;
                            run_sh   = 1'b1;
                            ticks_sh = '0;
                            ev       = EV_ACCEPT;
                        end
                        else begin
                            if (fails_sh < lim_cfg)
                                fails_sh = fails_sh + 1'b1;
                            ev = EV_REJECT;
                        end
                        entry_sh  = '0;
                        digits_sh = '0;
                    end
                end
                else if (key == KEY_CHANGE) begin
                    chg_sh   = 1'b1;
                    run_sh   = 1'b0;
                    ticks_sh = '0;
                end
                if (key >= KEY_DIGIT_FIRST && key <= KEY_DIGIT_LAST
                    && digits_sh < MAX_DIGITS) begin
                    entry_sh  = ENTRY_W'(int'(entry_sh) * 10
                                         + ((key == KEY_ZERO) ? 0 : int'(key)));
                    digits_sh = digits_sh + 1'b1;
                end
                if (key == KEY_DELETE && digits_sh != 0) begin
                    entry_sh  = ENTRY_W'(entry_sh / 10);
                    digits_sh = digits_sh - 1'b1;
                end
                if (key == KEY_SAVE && chg_sh) begin
                    code_sh   = entry_sh;
                    chg_sh    = 1'b0;
                    unl_sh    = 1'b0;
                    run_sh    = 1'b0;
                    ticks_sh  = '0;
                    entry_sh  = '0;
                    digits_sh = '0;
                    halt_sh   = 1'b1;
                    ev        = EV_SAVED;
                end
            end
            else if (run_sh) begin
                if (ticks_sh != TICK_MAX)
                    ticks_sh = ticks_sh + 1'b1;
                if (ticks_sh >= tmo_cfg) begin
                    run_sh   = 1'b0;
                    ticks_sh = '0;
                    halt_sh  = 1'b1;
                    ev       = EV_TIMEOUT;
                end
            end
        end
        v.entry  = entry_sh;
        v.digits = digits_sh;
        v.unl    = unl_sh;
        v.chg    = chg_sh;
        v.ev     = ev;
        v.alarm  = (fails_sh >= lim_cfg);
        v.halt   = halt_sh;
        return v;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            entry_sh   = '0;
            digits_sh  = '0;
            code_sh    = DEFAULT_CODE_RST;
            fails_sh   = '0;
            unl_sh     = 1'b0;
            chg_sh     = 1'b0;
            run_sh     = 1'b0;
            ticks_sh   = '0;
            halt_sh    = 1'b0;
            tmo_cfg    = TIMEOUT_TICKS_RST;
            lim_cfg    = FAILURE_LIMIT_RST;
            expected_views.delete();
            mismatches = 0;
            pending    = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DEFAULT_CODE:  code_sh = cfg_data[ENTRY_W-1:0];
                    CFG_TIMEOUT_TICKS: tmo_cfg = cfg_data[TICK_W-1:0];
                    CFG_FAILURE_LIMIT: lim_cfg = cfg_data[FAIL_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_views.push_back(predict_lock_view(func, key_code));
            if (out_valid && !out_stall) begin
                got = '{entry_value, digit_count, unlocked, change_mode, event_res,
                        alarm, halted};
                if (expected_views.size() == 0) begin
                    $display("%0t: result with no request waiting, entry %0d event %0d",
                             $time, entry_value, event_res);
                    mismatches++;
                end
                else begin
                    want = expected_views.pop_front();
                    check_field("entry_value", 16'(want.entry), 16'(got.entry));
                    check_field("digit_count", 16'(want.digits), 16'(got.digits));
                    check_field("unlocked", 16'(want.unl), 16'(got.unl));
                    check_field("change_mode", 16'(want.chg), 16'(got.chg));
                    check_field("event_res", 16'(want.ev), 16'(got.ev));
                    check_field("alarm", 16'(want.alarm), 16'(got.alarm));
                    check_field("halted", 16'(want.halt), 16'(got.halt));
                end
            end
            pending = expected_views.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the keypad code lock through one full life: locked entry with
// rejected codes and alarm settings, unlocking, timer ticks, and then either
// a code change that is saved or a timeout, both of which halt the lock.
// Requests and results idle and stall at random; the checker beside the
// block predicts every result and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import kcl_pkg::*;

    // Far above the slowest legal run (about a thousand requests, each with
    // long idle and stall tails, plus one long receiver hold-off).
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;

    // Keys with no function
    localparam logic [KEY_W-1:0] KEY_NONE   = '0;
    localparam logic [KEY_W-1:0] KEY_SPARE1 = KEY_DIGIT_LAST + 5'd1;
    localparam logic [KEY_W-1:0] KEY_SPARE2 = KEY_DIGIT_LAST + 5'd2;
    localparam logic [KEY_W-1:0] KEY_TOP    = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 func;
    logic [KEY_W-1:0]     key_code;
    logic                 out_valid;
    logic                 out_stall;
    logic [ENTRY_W-1:0]   entry_value;
    logic [COUNT_W-1:0]   digit_count;
    logic                 unlocked;
    logic                 change_mode;
    logic [EV_W-1:0]      event_res;
    logic                 alarm;
    logic                 halted;

    int                   mismatches;
    int                   pending;

    // Idle odds in percent per cycle for each side
    int                   send_idle;
    int                   recv_idle;
    bit                   hold_request;
    int                   hold_left;
    int                   cycle_count;

    // Bookkeeping for the unlock and the final timeout
    int                   ticks_since_unlock;
    int                   tick_base;
    int                   digit_value;
    logic [ENTRY_W-1:0]   unlock_code;
    logic [FAIL_W-1:0]    unlock_limit;
    logic [TICK_W-1:0]    final_timeout;

    keypad_code_lock uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .key_code    (key_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .entry_value (entry_value),
        .digit_count (digit_count),
        .unlocked    (unlocked),
        .change_mode (change_mode),
        .event_res   (event_res),
        .alarm       (alarm),
        .halted      (halted)
    );

    kcl_lock_checker lock_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .key_code    (key_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .entry_value (entry_value),
        .digit_count (digit_count),
        .unlocked    (unlocked),
        .change_mode (change_mode),
        .event_res   (event_res),
        .alarm       (alarm),
        .halted      (halted),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: stall at random, or hold off for a long stretch on
    // request so the block backs up and stalls its input.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // Offer one request and hold it until accepted. Idle cycles go in front
    // so valid is only ever raised in a step of its own.
    task automatic send_req(input logic kind, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= kind;
        key_code <= key;
        do
            @(posedge clk);
        while (in_stall);
        if (kind == FUNC_TICK)
            ticks_since_unlock++;
    endtask

    task automatic press(input logic [KEY_W-1:0] key);
        send_req(FUNC_KEY, key);
    endtask

    // Mostly digits, deletes and confirms, so entries are built and checked;
    // the rest is any code at all. Drop change or save where they would end
    // the current stage of the lock.
    function automatic logic [KEY_W-1:0] pick_key(input bit allow_change,
                                                  input bit allow_save);
        int unsigned      roll;
        logic [KEY_W-1:0] key;
        roll = $urandom_range(99);
        if (roll < 50)
            key = KEY_W'($urandom_range(KEY_DIGIT_LAST, KEY_DIGIT_FIRST));
        else if (roll < 62)
            key = KEY_DELETE;
        else if (roll < 80)
            key = KEY_CONFIRM;
        else
            key = KEY_W'($urandom);
        if ((key == KEY_CHANGE && !allow_change) || (key == KEY_SAVE && !allow_save))
            key = KEY_DELETE;
        return key;
    endfunction

    task automatic random_reqs(input int count, input bit allow_change,
                               input bit allow_save, input int tick_pct);
        repeat (count)
        begin
            if ($urandom_range(99) < tick_pct)
                send_req(FUNC_TICK, KEY_W'($urandom));
            else
                press(pick_key(allow_change, allow_save));
        end
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic wait_drained;
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // Write all three registers back to back; only call while drained.
    task automatic configure(input logic [ENTRY_W-1:0] code,
                             input logic [TICK_W-1:0] ticks,
                             input logic [FAIL_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEFAULT_CODE;
        cfg_data  <= CFG_W'(code);
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT_TICKS;
        cfg_data  <= CFG_W'(ticks);
        @(posedge clk);
        cfg_index <= CFG_FAILURE_LIMIT;
        cfg_data  <= CFG_W'(limit);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_DEFAULT_CODE;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        func      <= FUNC_KEY;
        key_code  <= KEY_NONE;
        send_idle = 36;
        recv_idle = 66;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at reset settings: keys with no effect while
        // locked, a full entry with one digit too many, empty and wrong
        // confirms up to the alarm and past it, deletes on empty and partial
        // entries, and ticks while the timer is stopped.
        press(KEY_NONE);
        press(KEY_SPARE1);
        press(KEY_SPARE2);
        press(KEY_TOP);
        press(KEY_CHANGE);
        press(KEY_SAVE);
        send_req(FUNC_TICK, KEY_CONFIRM);
        repeat (MAX_DIGITS + 1) press(KEY_W'(9));
        press(KEY_CONFIRM);
        press(KEY_CONFIRM);
        press(KEY_DELETE);
        press(KEY_W'(1));
        press(KEY_W'(2));
        press(KEY_W'(3));
        press(KEY_DELETE);
        press(KEY_ZERO);
        press(KEY_W'(4));
        press(KEY_CONFIRM);
        press(KEY_CONFIRM);
        send_req(FUNC_TICK, KEY_TOP);
        wait_drained();

        // Locked stages. Keep the stored code above 9999 so no random entry
        // can unlock; sweep the alarm limit over its lowest, highest and a
        // zero setting, and the timeout over its extremes.
        configure('1, TICK_W'(1), FAIL_W'(1));
        random_reqs(250, 1'b1, 1'b1, 15);
        wait_drained();

        send_idle = 66;
        recv_idle = 36;
        configure(ENTRY_W'($urandom_range(16383, 10000)),
                  TICK_W'($urandom_range(65535, 1)), '1);
        random_reqs(250, 1'b1, 1'b1, 15);
        wait_drained();

        configure(ENTRY_W'($urandom_range(16383, 10000)), '1, '0);
        random_reqs(60, 1'b1, 1'b1, 15);
        wait_drained();

        // Unlock: load a reachable code, clear the entry, type the code with
        // leading zeros and confirm. The longest timeout keeps the lock
        // awake through the unlocked stage.
        send_idle = 0;
        recv_idle = 0;
        case ($urandom_range(3))
            0:       unlock_code = '0;
            1:       unlock_code = ENTRY_W'(9999);
            default: unlock_code = ENTRY_W'($urandom_range(9999));
        endcase
        unlock_limit = FAIL_W'($urandom_range(15, 1));
        configure(unlock_code, '1, unlock_limit);
        repeat (MAX_DIGITS) press(KEY_DELETE);
        for (int i = MAX_DIGITS - 1; i >= 0; i--)
        begin
            digit_value = (int'(unlock_code) / (10 ** i)) % 10;
            press((digit_value == 0) ? KEY_ZERO : KEY_W'(digit_value));
        end
        press(KEY_CONFIRM);
        ticks_since_unlock = 0;
        press(KEY_CONFIRM);

        // Unlocked stage with the timer running; back the block up once.
        hold_request = 1'b1;
        random_reqs(200, 1'b0, 1'b1, 30);

        // Only one way out of the unlocked state per run, since reset is
        // never applied again: either save a new code or let the timer run
        // out at a timeout set close to the ticks counted so far.
        if ($urandom_range(1))
        begin
            press(KEY_CHANGE);
            press(KEY_CHANGE);
            random_reqs(80, 1'b1, 1'b0, 15);
            press(KEY_SAVE);
        end
        else
        begin
            wait_drained();
            tick_base     = ticks_since_unlock;
            final_timeout = TICK_W'($urandom_range(tick_base + 30,
                                                   (tick_base > 3) ? tick_base - 3 : 1));
            configure(unlock_code, final_timeout, unlock_limit);
            while (ticks_since_unlock <= tick_base
                   || ticks_since_unlock < int'(final_timeout) + 2)
                random_reqs(1, 1'b0, 1'b1, 75);
        end

        // Halted: everything is ignored from here on.
        random_reqs(10, 1'b1, 1'b1, 30);
        wait_drained();
        repeat (8) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
